FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on i_clk, held off during reset
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication on i_clk, held off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/irss_pkg.sv
`timescale 1ns / 1ps

package irss_pkg;

    localparam logic [2:0] ST_UNCHANGED = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_SPLIT     = 3'd3;
    localparam logic [2:0] ST_EXTENDED  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_QUERY     = 3'd6;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam int WR_SLOTS = 3;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_phase;

endpackage

FILE: src/irss_row_mem.sv
`timescale 1ns / 1ps

module irss_row_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int ROW_W  = 96
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ROW_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ROW_W-1:0]  o_rdata
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/irss_muldiv.sv
`timescale 1ns / 1ps

module irss_muldiv #(
    parameter int MAG_W  = 33,
    parameter int TIME_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic [TIME_W-1:0] i_tt,
    input  logic [TIME_W-1:0] i_dt,
    output logic              o_done,
    output logic [MAG_W-1:0]  o_quot,
    output logic              o_rem_nz
);

    localparam int PW = MAG_W + TIME_W;
    localparam int CW = $clog2(PW + 1);

    irss_pkg::t_md_phase r_ph;
    logic [PW-1:0]     r_acc;
    logic [TIME_W-1:0] r_mul_b;
    logic [MAG_W-1:0]  r_mag;
    logic [TIME_W-1:0] r_dt;
    logic [TIME_W-1:0] r_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_done;

    logic [PW-1:0]     op_a;
    logic [PW-1:0]     op_b;
    logic              op_sub;
    logic [PW:0]       sum;
    logic [TIME_W:0]   rem_sh;
    logic              ge;

    // one shared adder for both the shift-add multiply and the restoring divide
    always_comb begin
        rem_sh = {r_rem, r_acc[PW-1]};
        op_a   = {r_acc[PW-2:0], 1'b0};
        op_b   = r_mul_b[TIME_W-1] ? PW'(r_mag) : '0;
        op_sub = 1'b0;
        if (r_ph == irss_pkg::MD_DIV) begin
            op_a   = PW'(rem_sh);
            op_b   = PW'(r_dt);
            op_sub = 1'b1;
        end
        sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (PW+1)'(op_sub);
        ge  = sum[PW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= irss_pkg::MD_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                irss_pkg::MD_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_mul_b <= i_tt;
                        r_mag   <= i_mag;
                        r_dt    <= i_dt;
                        r_cnt   <= '0;
                        r_ph    <= irss_pkg::MD_MUL;
                    end
                end
                irss_pkg::MD_MUL: begin
                    r_acc   <= sum[PW-1:0];
                    r_mul_b <= {r_mul_b[TIME_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CW'(TIME_W - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_ph  <= irss_pkg::MD_DIV;
                    end
                end
                irss_pkg::MD_DIV: begin
                    r_rem <= ge ? sum[TIME_W-1:0] : rem_sh[TIME_W-1:0];
                    r_acc <= {r_acc[PW-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(PW - 1)) begin
                        r_done <= 1'b1;
                        r_ph   <= irss_pkg::MD_IDLE;
                    end
                end
                default: begin
                    r_ph <= irss_pkg::MD_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_acc[MAG_W-1:0];
    assign o_rem_nz = |r_rem;

endmodule

FILE: src/interval_run_series_store.sv
`timescale 1ns / 1ps
// a query scans the table's runs; when it interpolates it then runs a multiply and a divide
//   (shift-add multiply, then restoring divide in one shared adder)
// a record runs scan, row shifting, 3 write slots, then the report
// one item at a time through a row memory with one read and one write port, next item taken
//   once the result is registered; the worst case is set by an interpolating query
// synchronous active-low reset empties the table and sets interpolation on; rows are not cleared
`include "assert_macros.svh"

module interval_run_series_store #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_BITS  = 32,
    parameter int TIME_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // sample_value, sample_time
    input  logic [((VALUE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // run_count, read_value
    output logic [(($clog2(TABLE_DEPTH+1)+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // status, read_valid
    output logic [3:0] m_axis_tuser
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int RCW    = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_DW = ((RCW + VALUE_BITS + 7) / 8) * 8;
    localparam int MV     = VALUE_BITS + 1;
    localparam int ROW_W  = 2 * TIME_BITS + VALUE_BITS;

    typedef struct packed {
        logic [TIME_BITS-1:0]  s;
        logic [TIME_BITS-1:0]  e;
        logic [VALUE_BITS-1:0] v;
    } t_row;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_MATH,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_interp;

    logic                  r_op;
    logic [VALUE_BITS-1:0] r_v;
    logic [TIME_BITS-1:0]  r_t;
    logic [RCW-1:0]        r_n;
    logic [RCW-1:0]        r_idx;
    logic [RCW-1:0]        r_pidx;
    logic                  r_pend;

    logic                  r_bj_ok;
    logic [AW-1:0]         r_bj;
    logic [TIME_BITS-1:0]  r_bjs;
    logic [VALUE_BITS-1:0] r_bjv;
    logic                  r_af;
    logic [AW-1:0]         r_ai;
    logic [TIME_BITS-1:0]  r_ae;
    logic [VALUE_BITS-1:0] r_av;
    logic [TIME_BITS-1:0]  r_pe;
    logic [VALUE_BITS-1:0] r_pv;
    logic [VALUE_BITS-1:0] r_v1;

    logic [RCW-1:0]  r_pos;
    logic [1:0]      r_amt;
    logic [1:0]      r_slot;
    logic            r_wen  [irss_pkg::WR_SLOTS];
    logic [AW-1:0]   r_wad  [irss_pkg::WR_SLOTS];
    t_row            r_wrow [irss_pkg::WR_SLOTS];

    logic [2:0]            r_st;
    logic [VALUE_BITS-1:0] r_rval;
    logic                  r_rvalid;

    logic                  r_md_start;
    logic [TIME_BITS-1:0]  r_tt;
    logic [TIME_BITS-1:0]  r_dt;

    logic                  r_ovalid;
    logic [2:0]            r_o_st;
    logic [RCW-1:0]        r_o_cnt;
    logic [VALUE_BITS-1:0] r_o_val;
    logic                  r_o_rv;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [ROW_W-1:0]  mem_rdata;
    t_row              rd;
    logic [RCW-1:0]    km1;

    logic              cov;
    logic              after_t;
    logic              before_t;
    logic              full1;
    logic              full2;
    logic [AW-1:0]     i0;
    logic [AW-1:0]     i1;
    logic [AW-1:0]     i2;

    logic [MV-1:0]     vs0;
    logic [MV-1:0]     vs1;
    logic              down;
    logic [MV-1:0]     mag;
    logic [MV-1:0]     quot;
    logic              rem_nz;
    logic              md_done;
    logic [MV-1:0]     base;
    logic [MV-1:0]     fixed;

    assign rd       = t_row'(mem_rdata);
    assign km1      = r_idx - 1'b1;
    assign cov      = (rd.e >= r_t) && (rd.s <= r_t);
    assign after_t  = rd.s > r_t;
    assign before_t = rd.e < r_t;
    assign full1    = r_n >= RCW'(TABLE_DEPTH);
    assign full2    = r_n >= RCW'(TABLE_DEPTH - 1);
    assign i0       = r_pidx[AW-1:0];
    assign i1       = AW'(r_pidx + 1'b1);
    assign i2       = AW'(r_pidx + 2'd2);

    always_comb begin
        mem_we    = 1'b0;
        mem_raddr = r_idx[AW-1:0];
        mem_waddr = AW'(r_pidx + RCW'(r_amt));
        mem_wdata = mem_rdata;
        case (r_state)
            S_SHIFT: begin
                mem_raddr = km1[AW-1:0];
                mem_we    = r_pend;
            end
            S_WRITE: begin
                mem_we    = r_wen[r_slot];
                mem_waddr = r_wad[r_slot];
                mem_wdata = r_wrow[r_slot];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    irss_row_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW),
        .ROW_W  (ROW_W)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // signed interpolation around the unsigned multiply-divide
    always_comb begin
        vs0  = {r_pv[VALUE_BITS-1], r_pv};
        vs1  = {r_v1[VALUE_BITS-1], r_v1};
        down = $signed(vs1) < $signed(vs0);
        mag  = down ? (vs0 - vs1) : (vs1 - vs0);
        base = down ? (vs0 - quot) : (vs0 + quot);
        fixed = base;
        if (rem_nz && !down && base[MV-1]) begin
            fixed = base + 1'b1;
        end else if (rem_nz && down && !base[MV-1] && (base != '0)) begin
            fixed = base - 1'b1;
        end
    end

    irss_muldiv #(
        .MAG_W  (MV),
        .TIME_W (TIME_BITS)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_md_start),
        .i_mag    (mag),
        .i_tt     (r_tt),
        .i_dt     (r_dt),
        .o_done   (md_done),
        .o_quot   (quot),
        .o_rem_nz (rem_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_interp <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_n        <= '0;
            r_pend     <= 1'b0;
            r_md_start <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_md_start <= 1'b0;
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tuser;
                        r_v      <= s_axis_tdata[VALUE_BITS-1:0];
                        r_t      <= s_axis_tdata[VALUE_BITS+TIME_BITS-1:VALUE_BITS];
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_bj_ok  <= 1'b0;
                        r_af     <= 1'b0;
                        r_rval   <= '0;
                        r_rvalid <= 1'b0;
                        r_pv     <= '0;
                        r_amt    <= '0;
                        r_slot   <= '0;
                        for (int k = 0; k < irss_pkg::WR_SLOTS; k++) begin
                            r_wen[k] <= 1'b0;
                        end
                        if (s_axis_tuser == irss_pkg::OP_QUERY) begin
                            r_st     <= irss_pkg::ST_QUERY;
                            r_rvalid <= (r_n != '0);
                            r_state  <= (r_n == '0) ? S_DONE : S_SCAN;
                        end else if (r_n == '0) begin
                            r_st      <= irss_pkg::ST_INSERTED;
                            r_wen[0]  <= 1'b1;
                            r_wad[0]  <= '0;
                            r_wrow[0] <= '{s: s_axis_tdata[VALUE_BITS+TIME_BITS-1:VALUE_BITS],
                                           e: s_axis_tdata[VALUE_BITS+TIME_BITS-1:VALUE_BITS],
                                           v: s_axis_tdata[VALUE_BITS-1:0]};
                            r_amt     <= 2'd1;
                            r_state   <= S_WRITE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_n) begin
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                        r_pidx <= r_idx;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (r_op == irss_pkg::OP_QUERY) begin
                            if (after_t) begin
                                r_pend <= 1'b0;
                                if (r_pidx == '0) begin
                                    r_rval  <= rd.v;
                                    r_state <= S_DONE;
                                end else if (r_pidx == RCW'(1) || r_t <= r_pe || !r_interp
                                             || rd.s <= r_pe) begin
                                    r_rval  <= r_pv;
                                    r_state <= S_DONE;
                                end else begin
                                    r_v1       <= rd.v;
                                    r_tt       <= r_t - r_pe;
                                    r_dt       <= rd.s - r_pe;
                                    r_md_start <= 1'b1;
                                    r_state    <= S_MATH;
                                end
                            end else begin
                                r_pe <= rd.e;
                                r_pv <= rd.v;
                            end
                        end else if (cov) begin
                            r_pend <= 1'b0;
                            r_pos  <= RCW'(r_pidx + 1'b1);
                            if (rd.v == r_v) begin
                                r_st    <= irss_pkg::ST_UNCHANGED;
                                r_state <= S_DONE;
                            end else if (rd.e == r_t && rd.s == r_t) begin
                                r_st      <= irss_pkg::ST_REPLACED;
                                r_wen[0]  <= 1'b1;
                                r_wad[0]  <= i0;
                                r_wrow[0] <= '{s: rd.s, e: rd.e, v: r_v};
                                r_state   <= S_WRITE;
                            end else if (rd.e == r_t || rd.s == r_t) begin
                                r_st      <= full1 ? irss_pkg::ST_FULL : irss_pkg::ST_SPLIT;
                                r_amt     <= 2'd1;
                                r_idx     <= r_n;
                                r_wen[0]  <= 1'b1;
                                r_wen[1]  <= 1'b1;
                                if (rd.e == r_t) begin
                                    r_wad[0]  <= i0;
                                    r_wrow[0] <= '{s: rd.s, e: rd.s, v: rd.v};
                                    r_wad[1]  <= i1;
                                    r_wrow[1] <= '{s: r_t, e: r_t, v: r_v};
                                end else begin
                                    r_wad[0]  <= i1;
                                    r_wrow[0] <= '{s: rd.e, e: rd.e, v: rd.v};
                                    r_wad[1]  <= i0;
                                    r_wrow[1] <= '{s: r_t, e: r_t, v: r_v};
                                end
                                r_state   <= full1 ? S_DONE : S_SHIFT;
                            end else begin
                                r_st      <= full2 ? irss_pkg::ST_FULL : irss_pkg::ST_SPLIT;
                                r_amt     <= 2'd2;
                                r_idx     <= r_n;
                                r_wen[0]  <= 1'b1;
                                r_wen[1]  <= 1'b1;
                                r_wen[2]  <= 1'b1;
                                r_wad[0]  <= i0;
                                r_wrow[0] <= '{s: rd.s, e: rd.s, v: rd.v};
                                r_wad[1]  <= i1;
                                r_wrow[1] <= '{s: r_t, e: r_t, v: r_v};
                                r_wad[2]  <= i2;
                                r_wrow[2] <= '{s: rd.e, e: rd.e, v: rd.v};
                                r_state   <= full2 ? S_DONE : S_SHIFT;
                            end
                        end else begin
                            if (before_t) begin
                                r_bj_ok <= 1'b1;
                                r_bj    <= i0;
                                r_bjs   <= rd.s;
                                r_bjv   <= rd.v;
                            end
                            if (after_t && !r_af) begin
                                r_af <= 1'b1;
                                r_ai <= i0;
                                r_ae <= rd.e;
                                r_av <= rd.v;
                            end
                        end
                    end else if (r_idx >= r_n) begin
                        // whole table seen without a break or a covering run
                        if (r_op == irss_pkg::OP_QUERY) begin
                            r_rval  <= r_pv;
                            r_state <= S_DONE;
                        end else if (r_bj_ok && r_bjv == r_v) begin
                            r_st      <= irss_pkg::ST_EXTENDED;
                            r_wen[0]  <= 1'b1;
                            r_wad[0]  <= r_bj;
                            r_wrow[0] <= '{s: r_bjs, e: r_t, v: r_bjv};
                            r_state   <= S_WRITE;
                        end else if (r_bj_ok) begin
                            r_st      <= full1 ? irss_pkg::ST_FULL : irss_pkg::ST_INSERTED;
                            r_amt     <= 2'd1;
                            r_pos     <= RCW'(r_bj) + 1'b1;
                            r_wen[0]  <= 1'b1;
                            r_wad[0]  <= AW'(RCW'(r_bj) + 1'b1);
                            r_wrow[0] <= '{s: r_t, e: r_t, v: r_v};
                            r_state   <= full1 ? S_DONE : S_SHIFT;
                        end else if (r_af && r_av == r_v) begin
                            r_st      <= irss_pkg::ST_EXTENDED;
                            r_wen[0]  <= 1'b1;
                            r_wad[0]  <= r_ai;
                            r_wrow[0] <= '{s: r_t, e: r_ae, v: r_av};
                            r_state   <= S_WRITE;
                        end else if (r_af) begin
                            r_st      <= full1 ? irss_pkg::ST_FULL : irss_pkg::ST_INSERTED;
                            r_amt     <= 2'd1;
                            r_pos     <= RCW'(r_ai);
                            r_wen[0]  <= 1'b1;
                            r_wad[0]  <= r_ai;
                            r_wrow[0] <= '{s: r_t, e: r_t, v: r_v};
                            r_state   <= full1 ? S_DONE : S_SHIFT;
                        end else begin
                            r_st    <= irss_pkg::ST_UNCHANGED;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    // rows move up from the top down, one read and one write a cycle
                    if (r_idx > r_pos) begin
                        r_idx  <= km1;
                        r_pend <= 1'b1;
                        r_pidx <= km1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (!r_pend && r_idx <= r_pos) begin
                        r_slot  <= '0;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == 2'(irss_pkg::WR_SLOTS - 1)) begin
                        r_n     <= r_n + RCW'(r_amt);
                        r_state <= S_DONE;
                    end
                end
                S_MATH: begin
                    if (md_done) begin
                        r_rval  <= fixed[VALUE_BITS-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_o_st   <= r_st;
                        r_o_cnt  <= r_n;
                        r_o_val  <= r_rval;
                        r_o_rv   <= r_rvalid;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_DW'({r_o_val, r_o_cnt});
    assign m_axis_tuser  = {r_o_rv, r_o_st};

    `ASSERT_NOW(a_count_bound, 1'b1, r_n <= RCW'(TABLE_DEPTH))
    `ASSERT_NOW(a_valid_only_query, m_axis_tvalid && (r_o_st != irss_pkg::ST_QUERY), !r_o_rv)
    `ASSERT_NOW(a_valid_nonempty, m_axis_tvalid && r_o_rv, r_o_cnt != '0)
    `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 6000;
    localparam int DRAIN      = 400;

    typedef struct {
        logic        op;
        logic [31:0] value;
        logic [31:0] stamp;
    } t_sample;

    typedef struct {
        logic [2:0]  status;
        logic [6:0]  count;
        logic [31:0] value;
        logic        valid;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    interval_run_series_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // run table copy
    logic [31:0] run_lo [DEPTH];
    logic [31:0] run_hi [DEPTH];
    logic [31:0] run_val[DEPTH];
    int          runs_held;
    logic        blend_on;

    t_sample pending_items[$];
    t_answer expected_answers[$];
    int      sent_cnt, taken_cnt, errors, idle_cycles;
    int      burst_left, gap_left, ready_mode, ready_timer;
    bit      driver_on;

    function automatic void open_row(int pos);
        for (int k = runs_held; k > pos; k--) begin
            run_lo[k]  = run_lo[k-1];
            run_hi[k]  = run_hi[k-1];
            run_val[k] = run_val[k-1];
        end
        runs_held++;
    endfunction

    function automatic void put_row(int i, logic [31:0] s, logic [31:0] e, logic [31:0] v);
        run_lo[i]  = s;
        run_hi[i]  = e;
        run_val[i] = v;
    endfunction

    function automatic logic [2:0] record_sample(logic [31:0] v, logic [31:0] t);
        int          n;
        logic [31:0] s, e, ov;
        n = runs_held;
        if (n == 0) begin
            put_row(0, t, t, v);
            runs_held = 1;
            return irss_pkg::ST_INSERTED;
        end
        for (int i = 0; i < n; i++) begin
            s = run_lo[i];
            e = run_hi[i];
            if (e >= t && s <= t) begin
                ov = run_val[i];
                if (ov == v) return irss_pkg::ST_UNCHANGED;
                if (e == t && s == t) begin
                    run_val[i] = v;
                    return irss_pkg::ST_REPLACED;
                end
                if (e == t) begin
                    if (n + 1 > DEPTH) return irss_pkg::ST_FULL;
                    run_hi[i] = s;
                    open_row(i + 1);
                    put_row(i + 1, t, t, v);
                    return irss_pkg::ST_SPLIT;
                end
                if (s == t) begin
                    if (n + 1 > DEPTH) return irss_pkg::ST_FULL;
                    run_lo[i] = e;
                    open_row(i);
                    put_row(i, t, t, v);
                    return irss_pkg::ST_SPLIT;
                end
                if (n + 2 > DEPTH) return irss_pkg::ST_FULL;
                run_hi[i] = s;
                open_row(i + 1);
                open_row(i + 1);
                put_row(i + 1, t, t, v);
                put_row(i + 2, e, e, ov);
                return irss_pkg::ST_SPLIT;
            end
        end
        for (int j = n - 1; j >= 0; j--) begin
            if (run_hi[j] < t) begin
                if (run_val[j] == v) begin
                    run_hi[j] = t;
                    return irss_pkg::ST_EXTENDED;
                end
                if (n + 1 > DEPTH) return irss_pkg::ST_FULL;
                open_row(j + 1);
                put_row(j + 1, t, t, v);
                return irss_pkg::ST_INSERTED;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (run_lo[i] > t) begin
                if (run_val[i] == v) begin
                    run_lo[i] = t;
                    return irss_pkg::ST_EXTENDED;
                end
                if (n + 1 > DEPTH) return irss_pkg::ST_FULL;
                open_row(i);
                put_row(i, t, t, v);
                return irss_pkg::ST_INSERTED;
            end
        end
        return irss_pkg::ST_UNCHANGED;
    endfunction

    // exact linear blend, truncated toward zero
    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] dt0, logic [31:0] span);
        longint       v0, v1;
        bit           down;
        logic [63:0]  mag, q, r, base;
        logic [127:0] prod;
        v0   = longint'(signed'(a));
        v1   = longint'(signed'(b));
        down = v1 < v0;
        mag  = down ? v0 - v1 : v1 - v0;
        prod = {64'd0, mag} * {96'd0, dt0};
        q    = 64'(prod / {96'd0, span});
        r    = 64'(prod % {96'd0, span});
        if (!down) begin
            base = v0 + q;
            if (r != 0 && base[63]) base = base + 1;
        end else begin
            base = v0 - q;
            if (r != 0 && !base[63] && base != 0) base = base - 1;
        end
        return base[31:0];
    endfunction

    function automatic logic [31:0] value_at(logic [31:0] t);
        int ne;
        ne = 0;
        for (int i = 0; i < runs_held; i++) begin
            if (run_lo[i] > t) break;
            ne = i;
        end
        if (ne == 0 || ne == runs_held - 1 || t <= run_hi[ne] || !blend_on)
            return run_val[ne];
        if (run_lo[ne+1] <= run_hi[ne]) return run_val[ne];
        return blend(run_val[ne], run_val[ne+1], t - run_hi[ne], run_lo[ne+1] - run_hi[ne]);
    endfunction

    function automatic t_answer predict_answer(logic op, logic [31:0] v, logic [31:0] t);
        t_answer a;
        a.value = '0;
        a.valid = 1'b0;
        if (op == irss_pkg::OP_RECORD) begin
            a.status = record_sample(v, t);
        end else begin
            a.status = irss_pkg::ST_QUERY;
            if (runs_held > 0) begin
                a.value = value_at(t);
                a.valid = 1'b1;
            end
        end
        a.count = 7'(runs_held);
        return a;
    endfunction

    task automatic add_item(logic op, logic [31:0] v, logic [31:0] t);
        t_sample it;
        it.op    = op;
        it.value = v;
        it.stamp = t;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [31:0] pick_time();
        int r, row;
        r = $urandom_range(0, 4);
        if (runs_held > 0 && r <= 1) begin
            row = $urandom_range(0, runs_held - 1);
            return (r == 0 ? run_lo[row] : run_hi[row]) + 32'($urandom_range(0, 2)) - 32'd1;
        end
        if (r == 2) return 32'($urandom_range(0, 300));
        if (r == 3) return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0 && runs_held > 0) return run_val[$urandom_range(0, runs_held - 1)];
        if (r == 1) return 32'($urandom_range(0, 3)) - 32'd1;
        if (r == 2) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 1000))};
        return $urandom;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_answers.size() != 0
               || sent_cnt != taken_cnt)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_blend(logic en);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= en;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        blend_on = en;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // sender
    always @(negedge i_clk) begin
        if (!(s_axis_tvalid && sent_cnt != taken_cnt)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (driver_on && pending_items.size() != 0) begin
                t_sample it;
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.op;
                s_axis_tdata  <= {it.stamp, it.value};
                sent_cnt++;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (ready_timer == 0) begin
            ready_mode  = $urandom_range(0, 3);
            ready_timer = $urandom_range(20, 300);
        end else begin
            ready_timer--;
        end
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ($urandom_range(0, 60) == 0);
        endcase
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_answers.insert(expected_answers.size(), predict_answer(s_axis_tuser,
                    s_axis_tdata[31:0], s_axis_tdata[63:32]));
                taken_cnt++;
                idle_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                if (expected_answers.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected item: %h %h", m_axis_tuser, m_axis_tdata);
                end else begin
                    t_answer w;
                    w = expected_answers.pop_front();
                    if (m_axis_tuser[2:0] !== w.status || m_axis_tdata[6:0] !== w.count ||
                        m_axis_tdata[38:7] !== w.value || m_axis_tuser[3] !== w.valid) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %0d %0d %h %b got %0d %0d %h %b",
                                     w.status, w.count, w.value, w.valid, m_axis_tuser[2:0],
                                     m_axis_tdata[6:0], m_axis_tdata[38:7], m_axis_tuser[3]);
                    end
                end
            end
            if (idle_cycles > IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = irss_pkg::OP_RECORD;
        m_axis_tready = 1'b0;
        sent_cnt = 0; taken_cnt = 0; errors = 0; idle_cycles = 0;
        burst_left = 0; gap_left = 0; ready_mode = 0; ready_timer = 0;
        driver_on = 1'b0;
        runs_held = 0;
        blend_on  = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        add_item(irss_pkg::OP_QUERY,  32'd5,          32'd100);
        add_item(irss_pkg::OP_RECORD, 32'h7FFF_FFFF,  32'd0);
        add_item(irss_pkg::OP_RECORD, 32'h7FFF_FFFF,  32'd0);
        add_item(irss_pkg::OP_RECORD, 32'd10,         32'd0);
        add_item(irss_pkg::OP_RECORD, 32'h8000_0000,  32'hFFFF_FFFF);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'h8000_0000);
        add_item(irss_pkg::OP_RECORD, 32'd50,         32'd1000);
        add_item(irss_pkg::OP_RECORD, 32'd50,         32'd2000);
        add_item(irss_pkg::OP_RECORD, 32'd50,         32'd500);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'd1500);
        add_item(irss_pkg::OP_RECORD, 32'd51,         32'd1200);
        add_item(irss_pkg::OP_RECORD, 32'd52,         32'd2000);
        add_item(irss_pkg::OP_RECORD, 32'd53,         32'd500);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'd250);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'd700);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'd1100);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'd3000);
        add_item(irss_pkg::OP_RECORD, 32'hFFFF_FFF0,  32'd20000);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'd12345);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'hFFFF_FFFE);
        add_item(irss_pkg::OP_RECORD, 32'd7,          32'd3);
        add_item(irss_pkg::OP_QUERY,  32'd0,          32'd1);
        driver_on = 1'b1;
        wait_idle();

        // random phases, alternating interpolation
        for (int ph = 0; ph < 10; ph++) begin
            write_blend(ph[0]);
            for (int k = 0; k < 200; k++)
                add_item($urandom_range(0, 9) < 5 ? irss_pkg::OP_RECORD : irss_pkg::OP_QUERY,
                         pick_value(), pick_time());
            wait_idle();
        end

        if (errors == 0 && expected_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: interval_run_series_store.f
+incdir+src
src/irss_pkg.sv
src/irss_row_mem.sv
src/irss_muldiv.sv
src/interval_run_series_store.sv
test/tb_top.sv
